FILE: hdl/scpc_pkg.sv
`default_nettype none

package scpc_pkg;

    // Reference clock feeding the PLL and the slow-mode divider
    localparam logic [23:0] REF_HZ = 24'd12000000;

    localparam logic [7:0] PRE_MAX = 8'hff;

    localparam int SLOW_W = 5;
    localparam int PLL_W  = 20;
    localparam int DIVB_W = 2;
    localparam int CFG_W  = 20;
    localparam int IDX_W  = 2;

    // Bit position of the slow-mode select in the slow-mode word
    localparam int SLOW_BIT = 4;

    localparam int DIV_W = 32;
    localparam int CNT_W = 5;

    localparam logic [IDX_W-1:0] CFG_SLOW = 2'd0;
    localparam logic [IDX_W-1:0] CFG_PLL  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DIVB = 2'd2;

    // Operation codes carried in the func field
    localparam logic FUNC_SET_RATE  = 1'b0;
    localparam logic FUNC_SLOW_DOWN = 1'b1;

    typedef struct packed {
        logic        func;
        logic [25:0] requested_hz;
    } scpc_in_t;

    typedef struct packed {
        logic [30:0] system_clock_hz;
        logic [7:0]  prescaler_value;
        logic [29:0] sd_clock_hz;
        logic        changed;
    } scpc_out_t;

    typedef struct packed {
        logic load_in;
        logic start_pclk;
        logic fin_pclk;
        logic start_q;
        logic fin_q;
        logic slow_step;
        logic start_sd;
        logic load_out;
    } scpc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic func;
        logic out_free;
    } scpc_sts_t;

endpackage

`default_nettype wire

FILE: hdl/sd_clock_prescaler_calc.sv
`default_nettype none

// SD clock prescaler calculator. Each input word derives the peripheral clock
// from the 12 MHz reference and the slow-mode, PLL and divider registers, then
// either sets the 8-bit SD prescaler from a requested SD rate (func 0, rounded
// to nearest, clamped to 0..255) or slows the SD clock one step (func 1: below
// 4 add one, otherwise double, saturate at 255, report no change at 255). Every
// result word carries the peripheral clock, the prescaler and the SD clock
// pclk / (2 * (prescaler + 1)). All divisions run on one shared 32-bit
// restoring divider that retires one quotient bit per cycle. A func 0 word
// takes three divisions; a func 1 word takes two. One word is in work at a
// time; the next word is taken in the cycle after the result is loaded into
// the output register, and a stalled output register holds off that load.
// Write configuration only while the block is idle.
module sd_clock_prescaler_calc (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [scpc_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [scpc_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire scpc_pkg::scpc_in_t        in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output scpc_pkg::scpc_out_t            out_data
);
    import scpc_pkg::*;

    // Command and status between sequencer and datapath
    scpc_cmd_t cmd;
    scpc_sts_t sts;

    // Sequencer: steps the shared divider through pclk, rate quotient and SD clock
    scpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Datapath: config registers, prescaler state, divider and output register
    scpc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

FILE: hdl/scpc_div.sv
`default_nettype none

module scpc_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [scpc_pkg::DIV_W-1:0] dividend,
    input  wire logic [scpc_pkg::DIV_W-1:0] divisor,
    output logic                           done,
    output logic [scpc_pkg::DIV_W-1:0]     quotient
);
    import scpc_pkg::*;

    // Restoring divider, one quotient bit per cycle. A zero divisor yields all ones.
    logic [DIV_W-1:0] dq_reg, dq_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, dq_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            dq_next  = {dq_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == CNT_W'(DIV_W - 1)) |=> (done_reg && !busy_reg))
        else $error("divider did not finish after last step");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
`endif

endmodule

`default_nettype wire

FILE: hdl/scpc_dp.sv
`default_nettype none

module scpc_dp (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire scpc_pkg::scpc_cmd_t       cmd,
    output scpc_pkg::scpc_sts_t            sts,
    input  wire logic                      cfg_we,
    input  wire logic [scpc_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [scpc_pkg::CFG_W-1:0] cfg_data,
    input  wire scpc_pkg::scpc_in_t        in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output scpc_pkg::scpc_out_t            out_data
);
    import scpc_pkg::*;

    logic [SLOW_W-1:0] slow_reg;
    logic [PLL_W-1:0]  pll_reg;
    logic [DIVB_W-1:0] divb_reg;
    logic              func_reg;
    logic [25:0]       req_reg;
    logic [DIV_W-1:0]  pclk_reg;
    logic [7:0]        pre_reg, pre_next;
    logic              changed_reg, changed_next;
    scpc_out_t         out_reg;
    logic              out_valid_reg, out_valid_next;

    logic             div_start;
    logic [DIV_W-1:0] div_dvd;
    logic [DIV_W-1:0] div_dvs;
    logic             div_done;
    logic [DIV_W-1:0] quot;

    logic [8:0]       pll_m;
    logic [5:0]       pll_p;
    logic [8:0]       pll_ps;
    logic [2:0]       slow_d;
    logic [DIV_W:0]   pll_prod;
    logic [DIV_W-1:0] half1;
    logic [DIV_W-1:0] half2;
    logic [8:0]       pre_dbl;

    assign pll_m    = 9'(pll_reg[19:12]) + 9'd8;
    assign pll_p    = 6'(pll_reg[8:4]) + 6'd2;
    assign pll_ps   = 9'(pll_p) << pll_reg[1:0];
    assign slow_d   = slow_reg[2:0];
    assign pll_prod = 33'(pll_m) * 33'(REF_HZ);

    always_comb
    begin
        div_start = cmd.start_pclk | cmd.start_q | cmd.start_sd;
        div_dvd   = '0;
        div_dvs   = '0;
        priority if (cmd.start_pclk)
        begin
            if (slow_reg[SLOW_BIT])
            begin
                div_dvd = DIV_W'(REF_HZ);
                div_dvs = (slow_d == 3'd0) ? DIV_W'(1) : DIV_W'({slow_d, 1'b0});
            end
            else
            begin
                div_dvd = pll_prod[DIV_W-1:0];
                div_dvs = DIV_W'(pll_ps);
            end
        end
        else if (cmd.start_q)
        begin
            div_dvd = pclk_reg + DIV_W'(req_reg);
            div_dvs = DIV_W'({req_reg, 1'b0});
        end
        else if (cmd.start_sd)
        begin
            div_dvd = pclk_reg;
            div_dvs = DIV_W'({9'(pre_reg) + 9'd1, 1'b0});
        end
    end

    scpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (quot)
    );

    assign half1   = divb_reg[1] ? (quot >> 1) : quot;
    assign half2   = divb_reg[0] ? (half1 >> 1) : half1;
    assign pre_dbl = {pre_reg, 1'b0};

    always_comb
    begin
        pre_next     = pre_reg;
        changed_next = changed_reg;
        if (cmd.fin_q)
        begin
            changed_next = 1'b1;
            priority if (quot == '0)
                pre_next = 8'd0;
            else if (quot > DIV_W'(256))
                pre_next = PRE_MAX;
            else
                pre_next = 8'(quot - 1'b1);
        end
        else if (cmd.slow_step)
        begin
            changed_next = (pre_reg != PRE_MAX);
            priority if (pre_reg == PRE_MAX)
                pre_next = pre_reg;
            else if (pre_reg < 8'd4)
                pre_next = pre_reg + 8'd1;
            else if (pre_dbl > 9'(PRE_MAX))
                pre_next = PRE_MAX;
            else
                pre_next = pre_dbl[7:0];
        end
    end

    assign sts.out_free = !out_valid_reg || !out_stall;
    assign sts.div_done = div_done;
    assign sts.func     = func_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_reg      <= '0;
            pll_reg       <= '0;
            divb_reg      <= '0;
            pre_reg       <= '0;
            changed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SLOW: slow_reg <= cfg_data[SLOW_W-1:0];
                    CFG_PLL:  pll_reg  <= cfg_data[PLL_W-1:0];
                    CFG_DIVB: divb_reg <= cfg_data[DIVB_W-1:0];
                    default:  ;
                endcase
            end
            pre_reg       <= pre_next;
            changed_reg   <= changed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= in_data.func;
            req_reg  <= in_data.requested_hz;
        end
        if (cmd.fin_pclk)
            pclk_reg <= half2;
        if (cmd.load_out)
        begin
            out_reg.system_clock_hz <= pclk_reg[30:0];
            out_reg.prescaler_value <= pre_reg;
            out_reg.sd_clock_hz     <= quot[29:0];
            out_reg.changed         <= changed_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_pre_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.fin_q && !cmd.slow_step) |=> $stable(pre_reg))
        else $error("prescaler moved without an update command");
`endif

endmodule

`default_nettype wire

FILE: hdl/scpc_ctrl.sv
`default_nettype none

module scpc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output scpc_pkg::scpc_cmd_t      cmd,
    input  wire scpc_pkg::scpc_sts_t sts
);
    import scpc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_PCLK    = 7'b0000010,
        S_QSTART  = 7'b0000100,
        S_QWAIT   = 7'b0001000,
        S_SDSTART = 7'b0010000,
        S_SDWAIT  = 7'b0100000,
        S_OUT     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in    = 1'b1;
                    cmd.start_pclk = 1'b1;
                    state_next     = S_PCLK;
                end
            end
            S_PCLK:
            begin
                if (sts.div_done)
                begin
                    cmd.fin_pclk = 1'b1;
                    if (sts.func == FUNC_SLOW_DOWN)
                    begin
                        cmd.slow_step = 1'b1;
                        state_next    = S_SDSTART;
                    end
                    else
                    begin
                        state_next = S_QSTART;
                    end
                end
            end
            S_QSTART:
            begin
                cmd.start_q = 1'b1;
                state_next  = S_QWAIT;
            end
            S_QWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.fin_q  = 1'b1;
                    state_next = S_SDSTART;
                end
            end
            S_SDSTART:
            begin
                cmd.start_sd = 1'b1;
                state_next   = S_SDWAIT;
            end
            S_SDWAIT:
            begin
                if (sts.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SDWAIT && sts.div_done) |=> (state_reg == S_OUT || state_reg == S_IDLE))
        else $error("result not handed to output stage");
`endif

endmodule

`default_nettype wire

FILE: dv/sd_clock_prescaler_calc_checker.sv
module sd_clock_prescaler_calc_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [scpc_pkg::IDX_W-1:0] cfg_index,
    input  logic [scpc_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  scpc_pkg::scpc_in_t        in_data,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  scpc_pkg::scpc_out_t       out_data,
    output int                        errors,
    output int                        pending
);
    import scpc_pkg::*;

    // Shadow copies of the block's registers and prescaler
    logic [SLOW_W-1:0] slow_word;
    logic [PLL_W-1:0]  pll_word;
    logic [DIVB_W-1:0] div_bits;
    logic [7:0]        sd_prescaler;

    scpc_out_t sd_results_due[$];
    int        mismatch_count = 0;
    int        outstanding = 0;
    int        words_checked = 0;

    assign errors  = mismatch_count;
    assign pending = outstanding;

    function automatic logic [63:0] peripheral_hz();
        logic [63:0] hz;
        logic [63:0] mult;
        logic [63:0] pre;
        hz = 64'(REF_HZ);
        if (slow_word[SLOW_BIT])
        begin
            if (slow_word[2:0] != 3'd0)
                hz = 64'(REF_HZ) / (64'(slow_word[2:0]) << 1);
        end
        else
        begin
            mult = 64'(pll_word[19:12]) + 64'd8;
            pre  = 64'(pll_word[8:4]) + 64'd2;
            hz   = (mult * 64'(REF_HZ)) / (pre << pll_word[1:0]);
        end
        if (div_bits[1])
            hz = hz >> 1;
        if (div_bits[0])
            hz = hz >> 1;
        return hz;
    endfunction

    // Advance the prescaler by one word and return the result it produces
    function automatic scpc_out_t step_prescaler(scpc_in_t w);
        logic [63:0] hz;
        logic [63:0] req;
        logic [63:0] quot;
        logic [8:0]  stepped;
        scpc_out_t   r;
        hz = peripheral_hz();
        req = 64'(w.requested_hz);
        r.changed = 1'b1;
        if (w.func == FUNC_SET_RATE)
        begin
            if (req == 64'd0)
                sd_prescaler = PRE_MAX;
            else
            begin
                quot = (hz + req) / (req << 1);
                if (quot == 64'd0)
                    sd_prescaler = 8'd0;
                else if (quot - 64'd1 > 64'(PRE_MAX))
                    sd_prescaler = PRE_MAX;
                else
                    sd_prescaler = 8'(quot - 64'd1);
            end
        end
        else if (sd_prescaler == PRE_MAX)
            r.changed = 1'b0;
        else
        begin
            // below four step by one, otherwise double and saturate
            stepped = (sd_prescaler < 8'd4) ? {1'b0, sd_prescaler} + 9'd1
                                            : {sd_prescaler, 1'b0};
            sd_prescaler = (stepped > 9'(PRE_MAX)) ? PRE_MAX : stepped[7:0];
        end
        r.system_clock_hz = hz[30:0];
        r.prescaler_value = sd_prescaler;
        quot = hz / ((64'(sd_prescaler) + 64'd1) << 1);
        r.sd_clock_hz = quot[29:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH word %0d %s: got %0d, expected %0d",
                 words_checked, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scpc_out_t want;
        if (!rst_n)
        begin
            slow_word    = '0;
            pll_word     = '0;
            div_bits     = '0;
            sd_prescaler = '0;
            sd_results_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SLOW: slow_word = cfg_data[SLOW_W-1:0];
                    CFG_PLL:  pll_word  = cfg_data[PLL_W-1:0];
                    CFG_DIVB: div_bits  = cfg_data[DIVB_W-1:0];
                    default:  ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (sd_results_due.size() == 0)
                    report_mismatch("unexpected result words", 64'd1, 64'd0);
                else
                begin
                    want = sd_results_due.pop_front();
                    if (out_data.system_clock_hz !== want.system_clock_hz)
                        report_mismatch("system_clock_hz", 64'(out_data.system_clock_hz),
                                        64'(want.system_clock_hz));
                    if (out_data.prescaler_value !== want.prescaler_value)
                        report_mismatch("prescaler_value", 64'(out_data.prescaler_value),
                                        64'(want.prescaler_value));
                    if (out_data.sd_clock_hz !== want.sd_clock_hz)
                        report_mismatch("sd_clock_hz", 64'(out_data.sd_clock_hz),
                                        64'(want.sd_clock_hz));
                    if (out_data.changed !== want.changed)
                        report_mismatch("changed", 64'(out_data.changed),
                                        64'(want.changed));
                end
                words_checked++;
            end
            if (in_valid && !in_stall)
                sd_results_due.push_back(step_prescaler(in_data));
        end
        outstanding = sd_results_due.size();
    end

endmodule

FILE: dv/sd_clock_prescaler_calc_test.sv
module sd_clock_prescaler_calc_test;

    import scpc_pkg::*;

    // Even with heavy idling on both sides, the thousand-odd words of the
    // run finish far below this.
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PHASES = 8;
    localparam int WORDS_PER_PHASE = 130;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    scpc_in_t         in_data;
    logic             out_valid;
    logic             out_stall;
    scpc_out_t        out_data;

    int errors;
    int pending;
    int cycle_count = 0;

    // Percent chance per cycle that the sender idles or the receiver stalls
    int idle_pct = 0;
    int stall_pct = 0;

    sd_clock_prescaler_calc uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    sd_clock_prescaler_calc_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: stall at random, decided at each falling edge
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Write one register; hold the enable for exactly one rising edge
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_clock_regs(logic [CFG_W-1:0] slow, logic [CFG_W-1:0] pll,
                                  logic [CFG_W-1:0] divb);
        write_reg(CFG_SLOW, slow);
        write_reg(CFG_PLL, pll);
        write_reg(CFG_DIVB, divb);
    endtask

    // Present one word, idling first at the current rate, and hold it until
    // the block takes it. Valid stays high afterward so back-to-back words
    // need no extra edge.
    task automatic send_word(logic func, logic [25:0] req);
        scpc_in_t w;
        w.func = func;
        w.requested_hz = req;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stop sending and hold off until every outstanding result is back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    // Spread requested rates over a log scale so every prescaler range
    // shows up, with zero, the all-ones rate and raw random bits mixed in.
    function automatic logic [25:0] random_rate();
        case ($urandom_range(19))
            0:       return 26'd0;
            1:       return 26'h3ffffff;
            2, 3:    return 26'($urandom);
            default: return 26'($urandom_range(50000000, 1) >> $urandom_range(20, 0));
        endcase
    endfunction

    initial
    begin
        int phase;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words on the reset settings (48 MHz peripheral clock).
        // Walk the slow-down from zero: step by one up to four, then double,
        // saturate past 128, then refuse at the maximum.
        repeat (11)
            send_word(FUNC_SLOW_DOWN, 26'h3ffffff);
        send_word(FUNC_SET_RATE, 26'd0);          // zero rate saturates
        send_word(FUNC_SLOW_DOWN, 26'd0);
        send_word(FUNC_SET_RATE, 26'd1);          // clamps at the top
        send_word(FUNC_SET_RATE, 26'h3ffffff);    // quotient of zero
        send_word(FUNC_SET_RATE, 26'd50000000);
        send_word(FUNC_SET_RATE, 26'd24000000);
        send_word(FUNC_SET_RATE, 26'd1000);
        send_word(FUNC_SET_RATE, 26'd12345);
        send_word(FUNC_SET_RATE, 26'd400000);
        send_word(FUNC_SLOW_DOWN, 26'h2aaaaaa);
        send_word(FUNC_SET_RATE, 26'h1555555);
        drain();

        // Random phases: each one writes a new clock setting (extremes first)
        // and cycles through the idling modes.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_clock_regs(20'h00000, 20'h00000, 20'd0);
                1: set_clock_regs(20'h0001f, 20'($urandom), 20'd3);  // slow, divide by 14 and by 4
                2: set_clock_regs(20'h00010, 20'h00000, 20'd0);      // slow, divider zero
                3: set_clock_regs(20'h0000f, 20'hfffff, 20'd1);
                4: set_clock_regs(20'h00000, 20'hff000, 20'd0);      // fastest PLL
                5: set_clock_regs(20'($urandom), 20'($urandom), 20'($urandom));
                6: set_clock_regs(20'h00000, 20'($urandom), 20'd2);
                default: set_clock_regs(20'($urandom), 20'($urandom), 20'($urandom));
            endcase
            case (phase % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 82;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 82;
                end
                default:
                begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase
            repeat (WORDS_PER_PHASE)
                send_word(($urandom_range(99) < 35) ? FUNC_SLOW_DOWN : FUNC_SET_RATE,
                          random_rate());
            drain();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sd_clock_prescaler_calc.f
hdl/scpc_pkg.sv
hdl/scpc_div.sv
hdl/scpc_dp.sv
hdl/scpc_ctrl.sv
hdl/sd_clock_prescaler_calc.sv
dv/sd_clock_prescaler_calc_checker.sv
dv/sd_clock_prescaler_calc_test.sv
